@@ rtl/core/ssfc_pkg.sv @@
package ssfc_pkg;

    typedef enum logic [2:0] {
        FMT_IBM   = 3'd0,
        FMT_IEEE  = 3'd1,
        FMT_INT32 = 3'd2,
        FMT_INT16 = 3'd3,
        FMT_INT8  = 3'd4
    } fmt_t;

    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_SWAP   = 1'b1;

    localparam logic [31:0] IBM_MAX_FINITE = 32'h7f7fffff;

    // stage 1 -> stage 2
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        is_ibm;
        logic        pass;
        logic        zero;
        logic        sign;
        logic [31:0] word;   // IBM: raw word; int: magnitude; IEEE: bits
    } s1_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        is_ibm;
        logic        pass;
        logic        zero;
        logic        sign;
        logic [6:0]  ibm_exp;
        logic [5:0]  lz;
        logic [31:0] norm;   // normalized: leading one at bit 31 (int) / 23 (ibm)
    } s2_t;

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/core/seismic_sample_to_float_converter.sv @@
// channel   dir  handshake              payload
// cmd       in   start & !busy          raw_sample, last_in_trace
// result    out  done strobe, 1 cycle   ieee_sample, last_of_trace
// cfg       in   cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Three register stages (decode, leading-zero normalize, round/pack),
// one sample per cycle. busy is always low, cfg_ready always high.
// Reset clears valid bits; sample_format resets to IBM, swap_bytes to 1.
// Results cannot be stalled.
module seismic_sample_to_float_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] raw_sample,
    input  logic        last_in_trace,
    output logic        done,
    output logic [31:0] ieee_sample,
    output logic        last_of_trace,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [2:0]    fmt_reg;
    logic          swap_reg;
    ssfc_pkg::s1_t s1;
    ssfc_pkg::s2_t s2;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= ssfc_pkg::FMT_IBM;
            swap_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ssfc_pkg::CFG_FORMAT)
            begin
                fmt_reg <= cfg_data[2:0];
            end
            else
            begin
                swap_reg <= cfg_data[0];
            end
        end
    end

    ssfc_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start),
        .raw_sample    (raw_sample),
        .last_in_trace (last_in_trace),
        .fmt           (fmt_reg),
        .swap          (swap_reg),
        .s1            (s1)
    );

    ssfc_normalize u_normalize (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    ssfc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2        (s2),
        .out_valid (done),
        .out_word  (ieee_sample),
        .out_last  (last_of_trace)
    );

endmodule

@@ rtl/core/ssfc_decode.sv @@
module ssfc_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         raw_sample,
    input  logic                last_in_trace,
    input  logic [2:0]          fmt,
    input  logic                swap,
    output ssfc_pkg::s1_t       s1
);

    ssfc_pkg::s1_t s1_reg;
    ssfc_pkg::s1_t s1_next;
    logic [31:0]   w32;
    logic [31:0]   sval;

    assign w32 = swap ? {raw_sample[7:0], raw_sample[15:8], raw_sample[23:16],
                         raw_sample[31:24]} : raw_sample;

    always_comb
    begin
        sval = 32'd0;
        s1_next = '0;
        s1_next.valid = in_valid;
        s1_next.last = last_in_trace;
        case (fmt)
            ssfc_pkg::FMT_IBM:
            begin
                s1_next.is_ibm = 1'b1;
                s1_next.word = w32;
                s1_next.zero = (w32[23:0] == 24'd0);
                s1_next.sign = w32[31];
            end
            ssfc_pkg::FMT_IEEE:
            begin
                s1_next.pass = 1'b1;
                s1_next.word = w32;
            end
            ssfc_pkg::FMT_INT32,
            ssfc_pkg::FMT_INT16,
            ssfc_pkg::FMT_INT8:
            begin
                if (fmt == ssfc_pkg::FMT_INT32)
                begin
                    sval = w32;
                end
                else if (fmt == ssfc_pkg::FMT_INT16)
                begin
                    sval = swap ? {{16{raw_sample[7]}}, raw_sample[7:0], raw_sample[15:8]}
                                : {{16{raw_sample[15]}}, raw_sample[15:0]};
                end
                else
                begin
                    sval = {{24{raw_sample[7]}}, raw_sample[7:0]};
                end
                s1_next.sign = sval[31];
                s1_next.word = sval[31] ? (32'd0 - sval) : sval;
                s1_next.zero = (sval == 32'd0);
            end
            default:
            begin
                s1_next.zero = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

@@ rtl/core/ssfc_normalize.sv @@
module ssfc_normalize (
    input  logic                clk,
    input  logic                rst_n,
    input  ssfc_pkg::s1_t       s1,
    output ssfc_pkg::s2_t       s2
);

    ssfc_pkg::s2_t s2_reg;
    ssfc_pkg::s2_t s2_next;
    logic [5:0]    lz;

    assign lz = ssfc_pkg::lzc32(s1.is_ibm ? {8'd0, s1.word[23:0]} : s1.word);

    always_comb
    begin
        s2_next.valid = s1.valid;
        s2_next.last = s1.last;
        s2_next.is_ibm = s1.is_ibm;
        s2_next.pass = s1.pass;
        s2_next.zero = s1.zero;
        s2_next.sign = s1.sign;
        s2_next.ibm_exp = s1.word[30:24];
        s2_next.lz = lz;
        if (s1.pass)
        begin
            s2_next.norm = s1.word;
        end
        else if (s1.is_ibm)
        begin
            s2_next.norm = {8'd0, s1.word[23:0]} << (lz - 6'd8);
        end
        else
        begin
            s2_next.norm = s1.word << lz[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

@@ rtl/core/ssfc_pack.sv @@
module ssfc_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  ssfc_pkg::s2_t       s2,
    output logic                out_valid,
    output logic [31:0]         out_word,
    output logic                out_last
);

    logic        valid_reg;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic        last_reg;
    logic signed [10:0] iexp;
    logic [24:0] keep;
    logic        rnd;
    logic [8:0]  iex;

    always_comb
    begin
        // IBM: 4*e - 130 - (lz - 8), lz counted over 32 bits
        iexp = 11'sd4 * $signed({4'd0, s2.ibm_exp}) - 11'sd122
               - $signed({5'd0, s2.lz});
        rnd = s2.norm[7] & ((s2.norm[6:0] != 7'd0) | s2.norm[8]);
        keep = {1'b0, s2.norm[31:8]} + {24'd0, rnd};
        iex = 9'd158 - {3'd0, s2.lz} + {8'd0, keep[24]};
        word_next = 32'd0;
        if (s2.pass)
        begin
            word_next = s2.norm;
        end
        else if (s2.zero)
        begin
            word_next = 32'd0;
        end
        else if (s2.is_ibm)
        begin
            if (iexp > 11'sd254)
            begin
                word_next = {s2.sign, 31'd0} | ssfc_pkg::IBM_MAX_FINITE;
            end
            else if (iexp <= 11'sd0)
            begin
                word_next = 32'd0;
            end
            else
            begin
                word_next = {s2.sign, iexp[7:0], s2.norm[22:0]};
            end
        end
        else
        begin
            word_next = {s2.sign, iex[7:0],
                         keep[24] ? keep[23:1] : keep[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= s2.last;
    end

    assign out_valid = valid_reg;
    assign out_word = word_reg;
    assign out_last = last_reg;

endmodule
